>>> rtl/core/assert_macros.svh
// Shared assertion macros for the maze set-merge core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define MWSM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define MWSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/mwsm_pkg.sv
package mwsm_pkg;

    // Default grid limits
    localparam int unsigned DEF_MAX_ROWS = 32;
    localparam int unsigned DEF_MAX_COLS = 32;

    // Field and register widths
    localparam int unsigned DIM_W    = 6;
    localparam int unsigned COORD_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SETS_W   = 11;
    localparam int unsigned SETS_MAX = 2047;

    // Register values after reset
    localparam logic [DIM_W-1:0] RESET_ROWS = 6'd32;
    localparam logic [DIM_W-1:0] RESET_COLS = 6'd32;

    // Configuration register indexes
    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    // Operation codes
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_WALL = 1'b1;

    // Wall directions
    localparam logic DIR_RIGHT = 1'b0;
    localparam logic DIR_DOWN  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OPENED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_JOINED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REINIT  = 2'd3;

    // Sequencer states
    typedef enum logic [7:0] {
        S_FILL       = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_READ_HERE  = 8'b0000_0100,
        S_READ_THERE = 8'b0000_1000,
        S_COMPARE    = 8'b0001_0000,
        S_SCAN       = 8'b0010_0000,
        S_DRAIN      = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    // Effective grid dimension: zero acts as one, overlarge values clamp to the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned limit);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = 6'd1;
        end else if (32'(v) > limit) begin
            res = DIM_W'(limit);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/maze_wall_set_merge.sv
// Set-merging core for Kruskal maze generation. Every cell of a MAX_ROWS x MAX_COLS
// grid carries a set label in a single-port-write label memory. A re-initialize
// transaction (tuser low) rewrites every label to its own cell index. A wall
// transaction checks bounds: an outside wall goes straight to its result, an
// inside one reads the two labels, an already joined one returns after the
// compare, and an opened wall relabels the whole memory at one entry per cycle.
// The block takes one transaction at a time and drops tready until its result is
// in the output register. After reset a clearing pass fills the labels before the
// first transaction is taken; configuration writes are taken at any time, the
// bounds check uses them at once and the set count on the next re-initialize.
`include "assert_macros.svh"

module maze_wall_set_merge
    import mwsm_pkg::*;
#(
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [5:0]   cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [4:0] cell_row, [9:5] cell_col, [10] direction
    input  logic         s_tuser,   // [0] operation
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [10:0] sets_remaining
    output logic [1:0]   m_tuser    // [1:0] status
);

    localparam int unsigned TOTAL  = MAX_ROWS * MAX_COLS;
    localparam int unsigned ADDR_W = $clog2(TOTAL);
    localparam int unsigned CNT_W  = $clog2(TOTAL + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    rows_used_reg, cols_used_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic                fill_report_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   here_addr_reg, there_addr_reg;
    logic [ADDR_W-1:0]   here_label_reg, there_label_reg;
    logic                pend_valid_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic                m_tvalid_reg;
    logic [SETS_W-1:0]   sets_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic [ADDR_W-1:0]   label_mem [TOTAL];
    logic [ADDR_W-1:0]   rd_data_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_wdata, mem_raddr;

    logic [DIM_W-1:0]    eff_rows, eff_cols;
    logic [11:0]         grid_cells;
    logic [CNT_W-1:0]    reset_count;
    logic                in_accept, out_free;
    logic [COORD_W-1:0]  in_row, in_col;
    logic                in_dir;
    logic [DIM_W-1:0]    nb_row, nb_col;
    logic                outside;
    logic [31:0]         here_lin;
    logic [ADDR_W-1:0]   here_addr, there_addr;
    logic                scan_hit;
    logic [SETS_W-1:0]   sets_sat;

    // Decode the incoming transaction
    assign in_row    = s_tdata[4:0];
    assign in_col    = s_tdata[9:5];
    assign in_dir    = s_tdata[10];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Effective grid and cell count
    assign eff_rows    = eff_dim(rows_used_reg, MAX_ROWS);
    assign eff_cols    = eff_dim(cols_used_reg, MAX_COLS);
    assign grid_cells  = 12'(eff_rows) * 12'(eff_cols);
    assign reset_count = CNT_W'(12'(eff_dim(RESET_ROWS, MAX_ROWS))
                                * 12'(eff_dim(RESET_COLS, MAX_COLS)));

    // Neighbour position and bounds check
    assign nb_row  = (in_dir == DIR_DOWN)  ? DIM_W'(in_row) + 6'd1 : DIM_W'(in_row);
    assign nb_col  = (in_dir == DIR_RIGHT) ? DIM_W'(in_col) + 6'd1 : DIM_W'(in_col);
    assign outside = (DIM_W'(in_row) >= eff_rows) || (DIM_W'(in_col) >= eff_cols)
                  || (nb_row >= eff_rows) || (nb_col >= eff_cols);

    // Linear addresses of the two cells
    assign here_lin   = 32'(in_row) * MAX_COLS + 32'(in_col);
    assign here_addr  = ADDR_W'(here_lin);
    assign there_addr = (in_dir == DIR_DOWN) ? ADDR_W'(here_lin + MAX_COLS)
                                             : ADDR_W'(here_lin + 32'd1);

    // Relabel hit on the entry read in the previous scan cycle
    assign scan_hit = pend_valid_reg && (rd_data_reg == there_label_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= RESET_ROWS;
            cols_used_reg <= RESET_COLS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROWS_USED: rows_used_reg <= cfg_wdata;
                REG_COLS_USED: cols_used_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = idx_reg;
        mem_raddr = idx_reg;
        unique case (state_reg)
            S_FILL: begin
                mem_we = 1'b1;
            end
            S_READ_HERE: begin
                mem_raddr = here_addr_reg;
            end
            S_READ_THERE: begin
                mem_raddr = there_addr_reg;
            end
            S_SCAN, S_DRAIN: begin
                mem_we    = scan_hit;
                mem_waddr = pend_addr_reg;
                mem_wdata = here_label_reg;
            end
            default: ;
        endcase
    end

    // Label memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            label_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= label_mem[mem_raddr];
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_FILL: begin
                if (idx_reg == LAST_ADDR) begin
                    state_next = fill_report_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == OP_INIT) begin
                        state_next = S_FILL;
                    end else if (outside) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_READ_HERE;
                    end
                end
            end
            S_READ_HERE:  state_next = S_READ_THERE;
            S_READ_THERE: state_next = S_COMPARE;
            S_COMPARE: begin
                state_next = (rd_data_reg == here_label_reg) ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (idx_reg == LAST_ADDR) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_FILL;
            idx_reg         <= '0;
            fill_report_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            count_reg       <= reset_count;
            status_reg      <= ST_REINIT;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_FILL: begin
                    idx_reg <= (idx_reg == LAST_ADDR) ? '0 : idx_reg + 1'b1;
                end
                S_IDLE: begin
                    idx_reg        <= '0;
                    pend_valid_reg <= 1'b0;
                    if (in_accept) begin
                        if (s_tuser == OP_INIT) begin
                            fill_report_reg <= 1'b1;
                            count_reg       <= CNT_W'(grid_cells);
                            status_reg      <= ST_REINIT;
                        end else if (outside) begin
                            status_reg <= ST_OUTSIDE;
                        end else begin
                            status_reg <= ST_JOINED;
                        end
                    end
                end
                S_COMPARE: begin
                    if (rd_data_reg != here_label_reg) begin
                        status_reg <= ST_OPENED;
                    end
                end
                S_SCAN: begin
                    pend_valid_reg <= 1'b1;
                    pend_addr_reg  <= idx_reg;
                    idx_reg        <= (idx_reg == LAST_ADDR) ? '0 : idx_reg + 1'b1;
                end
                S_DRAIN: begin
                    pend_valid_reg <= 1'b0;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Wall payload: addresses at accept, labels as they arrive
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            here_addr_reg  <= here_addr;
            there_addr_reg <= there_addr;
        end
        if (state_reg == S_READ_THERE) begin
            here_label_reg <= rd_data_reg;
        end
        if (state_reg == S_COMPARE) begin
            there_label_reg <= rd_data_reg;
        end
    end

    // Saturate the set count for the result
    assign sets_sat = (32'(count_reg) > SETS_MAX) ? SETS_W'(SETS_MAX) : SETS_W'(count_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FINISH && out_free) begin
            sets_reg     <= sets_sat;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(sets_reg);
    assign m_tuser  = m_status_reg;

    // Set count only moves on a re-initialize or at the end of a merge
    `MWSM_ASSERT_NEXT(a_count_hold, aclk, aresetn, !(in_accept && s_tuser == OP_INIT) && state_reg != S_DRAIN, count_reg == $past(count_reg))
    // Labels are written only by the fill pass or the relabel sweep
    `MWSM_ASSERT_SAME(a_write_phase, aclk, aresetn, mem_we, state_reg == S_FILL || state_reg == S_SCAN || state_reg == S_DRAIN)
    // The relabel sweep leaves only through the drain cycle
    `MWSM_ASSERT_NEXT(a_scan_exit, aclk, aresetn, state_reg == S_SCAN, state_reg == S_SCAN || state_reg == S_DRAIN)

endmodule

>>> dv/tb_maze_wall_set_merge.sv
module tb_maze_wall_set_merge
    import mwsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CELL_COUNT   = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int unsigned ITEM_TARGET  = 580;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    // a full relabel sweep plus some margin
    localparam int unsigned SETTLE_WAIT  = CELL_COUNT + 80;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SETS_W-1:0]   sets;
    } merge_result_t;

    typedef struct {
        bit                is_cfg;
        bit                cfg_idx;
        bit [DIM_W-1:0]    cfg_val;
        bit                op;
        bit [COORD_W-1:0]  row;
        bit [COORD_W-1:0]  col;
        bit                dir;
        bit                known;
        bit [STATUS_W-1:0] status;
        bit [SETS_W-1:0]   sets;
    } plan_row_t;

    typedef enum bit [1:0] {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;  // [4:0] cell_row, [9:5] cell_col, [10] direction
    logic        s_tuser   = 1'b0; // [0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;   // [10:0] sets_remaining
    logic [1:0]  m_tuser;   // [1:0] status

    // predictor state
    logic [9:0]     cell_set_id [CELL_COUNT];
    int unsigned    open_sets;
    logic [DIM_W-1:0] grid_rows;
    logic [DIM_W-1:0] grid_cols;

    merge_result_t results_due [$];
    plan_row_t     plan [$];
    int unsigned   items_accepted = 0;
    int unsigned   results_seen   = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   burst_left     = 0;
    int unsigned   cycle_count    = 0;
    rx_mode_t      rx_mode        = RX_OPEN;
    int unsigned   rx_hold        = 0;

    maze_wall_set_merge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Zero acts as one, anything past the limit acts as the limit
    function automatic int unsigned grid_span(input logic [DIM_W-1:0] v,
                                              input int unsigned lim);
        if (v == '0) return 1;
        if (int'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic void relabel_all_cells();
        for (int unsigned k = 0; k < CELL_COUNT; k++) cell_set_id[k] = k[9:0];
        open_sets = grid_span(grid_rows, DEF_MAX_ROWS) * grid_span(grid_cols, DEF_MAX_COLS);
    endfunction

    // Work out the result of one transaction and advance the label store
    function automatic merge_result_t merge_outcome(input bit op, input bit [4:0] r,
                                                    input bit [4:0] c, input bit dir);
        int unsigned   er, ec, nr, nc;
        logic [9:0]    here, there;
        merge_result_t res;
        er = grid_span(grid_rows, DEF_MAX_ROWS);
        ec = grid_span(grid_cols, DEF_MAX_COLS);
        if (op == OP_INIT) begin
            relabel_all_cells();
            res.status = ST_REINIT;
        end else begin
            nr = 32'(r);
            nc = 32'(c);
            if (dir == DIR_RIGHT) nc = 32'(c) + 1;
            else nr = 32'(r) + 1;
            if (r >= er || c >= ec || nr >= er || nc >= ec) begin
                res.status = ST_OUTSIDE;
            end else begin
                here  = cell_set_id[r * DEF_MAX_COLS + c];
                there = cell_set_id[nr * DEF_MAX_COLS + nc];
                if (here == there) begin
                    res.status = ST_JOINED;
                end else begin
                    // sweep the whole store, cells outside the grid too
                    for (int unsigned k = 0; k < CELL_COUNT; k++)
                        if (cell_set_id[k] == there) cell_set_id[k] = here;
                    if (open_sets > 0) open_sets--;
                    res.status = ST_OPENED;
                end
            end
        end
        res.sets = (open_sets > SETS_MAX) ? SETS_MAX[SETS_W-1:0] : open_sets[SETS_W-1:0];
        return res;
    endfunction

    function automatic void plan_cfg(input bit idx, input bit [DIM_W-1:0] val);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg  = 1'b1;
        p.cfg_idx = idx;
        p.cfg_val = val;
        plan.insert(plan.size(), p);
    endfunction

    function automatic void plan_item(input bit op, input bit [4:0] r, input bit [4:0] c,
                                      input bit dir, input bit known,
                                      input bit [STATUS_W-1:0] st, input bit [SETS_W-1:0] sets);
        plan_row_t p;
        p = '{default: '0};
        p.op     = op;
        p.row    = r;
        p.col    = c;
        p.dir    = dir;
        p.known  = known;
        p.status = st;
        p.sets   = sets;
        plan.insert(plan.size(), p);
    endfunction

    // Offer one transaction in bursts with random gaps; queue what it should return
    task automatic send_item(input bit op, input bit [4:0] r, input bit [4:0] c,
                             input bit dir, input bit known = 1'b0,
                             input bit [STATUS_W-1:0] st = '0,
                             input bit [SETS_W-1:0] sets = '0);
        int unsigned   gap;
        merge_result_t want;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, dir, c, r};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_accepted++;
        want = merge_outcome(op, r, c, dir);
        if (known) begin
            want.status = st;
            want.sets   = sets;
        end
        results_due.insert(results_due.size(), want);
    endtask

    // Hold the input side idle until every outstanding result is back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_seen != items_accepted);
    endtask

    task automatic write_reg(input bit idx, input bit [DIM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ROWS_USED) grid_rows = val;
        else grid_cols = val;
        @(posedge aclk);
    endtask

    // Mostly small grids, with the clamped extremes now and then
    function automatic bit [DIM_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd32;
            2:       return 6'($urandom_range(33, 63));
            3:       return 6'd1;
            default: return 6'($urandom_range(2, 8));
        endcase
    endfunction

    // Receiver: switch between open, choppy and starved stretches
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_hold <= $urandom_range(20, 200);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_CHOPPY:  m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        merge_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding (status %0d)",
                                          m_tuser));
            end else begin
                want = results_due.pop_front();
                results_seen++;
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, m_tuser, want.status));
                if (m_tdata[SETS_W-1:0] !== want.sets)
                    report_mismatch($sformatf("result %0d sets_remaining %0d, want %0d",
                                              results_seen, m_tdata[SETS_W-1:0], want.sets));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned er, ec, pick, which, phase_len;

        grid_rows = RESET_ROWS;
        grid_cols = RESET_COLS;
        relabel_all_cells();

        //        op       row  col  dir        known status      sets
        plan_item(OP_WALL, 0,   0,   DIR_RIGHT, 1, ST_OPENED,  1023);
        plan_item(OP_WALL, 0,   0,   DIR_RIGHT, 1, ST_JOINED,  1023);
        plan_item(OP_WALL, 0,   1,   DIR_DOWN,  1, ST_OPENED,  1022);
        plan_item(OP_WALL, 31,  31,  DIR_RIGHT, 1, ST_OUTSIDE, 1022);
        plan_item(OP_WALL, 31,  0,   DIR_DOWN,  1, ST_OUTSIDE, 1022);
        plan_item(OP_WALL, 31,  31,  DIR_DOWN,  1, ST_OUTSIDE, 1022);
        plan_item(OP_WALL, 30,  31,  DIR_DOWN,  0, '0,         0);
        plan_item(OP_WALL, 31,  30,  DIR_RIGHT, 0, '0,         0);
        plan_item(OP_INIT, 31,  31,  DIR_DOWN,  1, ST_REINIT,  1024);
        // zero dimensions act as a single cell
        plan_cfg(REG_ROWS_USED, 6'd0);
        plan_cfg(REG_COLS_USED, 6'd0);
        plan_item(OP_INIT, 0,   0,   DIR_RIGHT, 1, ST_REINIT,  1);
        plan_item(OP_WALL, 0,   0,   DIR_RIGHT, 1, ST_OUTSIDE, 1);
        plan_item(OP_WALL, 0,   0,   DIR_DOWN,  1, ST_OUTSIDE, 1);
        // overlarge row count clamps to the full height
        plan_cfg(REG_ROWS_USED, 6'd63);
        plan_cfg(REG_COLS_USED, 6'd2);
        plan_item(OP_INIT, 0,   0,   DIR_RIGHT, 1, ST_REINIT,  64);
        plan_item(OP_WALL, 0,   0,   DIR_RIGHT, 0, '0,         0);
        plan_item(OP_WALL, 31,  0,   DIR_RIGHT, 0, '0,         0);
        plan_item(OP_WALL, 0,   1,   DIR_RIGHT, 1, ST_OUTSIDE, 62);
        plan_item(OP_WALL, 31,  1,   DIR_DOWN,  1, ST_OUTSIDE, 62);
        plan_item(OP_WALL, 0,   0,   DIR_DOWN,  0, '0,         0);
        // tiny count, then widen the grid without re-initializing: count floors at zero
        plan_cfg(REG_ROWS_USED, 6'd1);
        plan_item(OP_INIT, 0,   0,   DIR_RIGHT, 1, ST_REINIT,  2);
        plan_cfg(REG_ROWS_USED, 6'd32);
        plan_cfg(REG_COLS_USED, 6'd32);
        plan_item(OP_WALL, 0,   0,   DIR_RIGHT, 0, '0,         0);
        plan_item(OP_WALL, 5,   5,   DIR_DOWN,  0, '0,         0);
        plan_item(OP_WALL, 7,   7,   DIR_RIGHT, 1, ST_OPENED,  0);
        // owning cell itself below the grid
        plan_cfg(REG_ROWS_USED, 6'd4);
        plan_item(OP_WALL, 20,  3,   DIR_RIGHT, 1, ST_OUTSIDE, 0);

        // hold reset, then let the clearing pass run out behind tready
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_all_results();
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                send_item(plan[i].op, plan[i].row, plan[i].col, plan[i].dir,
                          plan[i].known, plan[i].status, plan[i].sets);
            end
        end

        // random phases: new grid, usually a re-initialize, then a run of walls
        while (items_accepted < ITEM_TARGET) begin
            wait_all_results();
            which = $urandom_range(0, 3);
            if (which != 1) write_reg(REG_ROWS_USED, pick_span());
            if (which != 2) write_reg(REG_COLS_USED, pick_span());
            if ($urandom_range(0, 4) != 0)
                send_item(OP_INIT, 5'($urandom), 5'($urandom), 1'($urandom));
            er = grid_span(grid_rows, DEF_MAX_ROWS);
            ec = grid_span(grid_cols, DEF_MAX_COLS);
            phase_len = $urandom_range(8, 40);
            repeat (phase_len) begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    send_item(OP_INIT, 5'($urandom), 5'($urandom), 1'($urandom));
                else if (pick < 5)
                    send_item(OP_WALL, 5'($urandom), 5'($urandom), 1'($urandom));
                else
                    send_item(OP_WALL, 5'($urandom_range(0, er - 1)),
                              5'($urandom_range(0, ec - 1)), 1'($urandom));
                if ($urandom_range(0, 59) == 0) wait_all_results();
            end
        end

        wait_all_results();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
